@@ rtl/drle_pkg.sv @@
// ----------------------------------------------------------------------------
// drle_pkg
// Types, constants and the CRC-32 byte step shared by the encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package drle_pkg;

    localparam int unsigned CRC_W   = 32;
    localparam int unsigned TOTAL_W = 48;

    localparam logic [CRC_W-1:0]   CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]   CRC_POLY  = 32'hEDB8_8320;
    localparam logic [7:0]         RUN_MAX   = 8'd255;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [7:0] CFG_DELTA_ENABLE = 8'd0;
    localparam logic [7:0] CFG_STORED_MODE  = 8'd1;

    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_STORED  = 2'd1,
        KIND_TRAILER = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        t_kind              out_kind;
        logic [7:0]         out_count;
        logic [7:0]         out_value;
        logic [CRC_W-1:0]   out_crc;
        logic [TOTAL_W-1:0] out_total;
        logic               out_last;
    } t_out_item;

    // results caused by one input byte: a closed run pair, then a stored
    // byte or the final run pair, then the trailer
    typedef struct packed {
        logic               a_valid;
        logic [7:0]         a_count;
        logic [7:0]         a_value;
        logic               b_valid;
        t_kind              b_kind;
        logic [7:0]         b_count;
        logic [7:0]         b_value;
        logic               t_valid;
        logic [CRC_W-1:0]   t_crc;
        logic [TOTAL_W-1:0] t_total;
    } t_rec;

    // reflected CRC-32, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/drle_front.sv @@
// ----------------------------------------------------------------------------
// drle_front
// Accept raw bytes, update CRC, count and run state, build result records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drle_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  drle_pkg::t_in_item i_in,
    output logic               o_full,
    input  logic               i_delta_enable,
    input  logic               i_stored_mode,
    output logic               o_rec_push,
    output drle_pkg::t_rec     o_rec,
    input  logic               i_rec_full
);

    logic [7:0]                   r_prev,    n_prev;
    logic [7:0]                   r_run_val, n_run_val;
    logic [7:0]                   r_run_len, n_run_len;
    logic [drle_pkg::CRC_W-1:0]   r_crc,     n_crc;
    logic [drle_pkg::TOTAL_W-1:0] r_total,   n_total;

    logic                         accept;
    logic                         first;
    logic [7:0]                   coded;
    logic [7:0]                   len_nx;
    logic [7:0]                   val_nx;
    logic [drle_pkg::CRC_W-1:0]   crc_nx;
    logic [drle_pkg::TOTAL_W-1:0] total_nx;
    drle_pkg::t_rec               rec;

    assign accept = i_push && !i_rec_full;
    assign o_full = i_rec_full;

    always_comb begin
        first    = (r_total == '0);
        crc_nx   = drle_pkg::crc_byte(r_crc, i_in.in_byte);
        total_nx = (r_total == drle_pkg::TOTAL_MAX) ? r_total : r_total + 1'b1;
        coded    = (i_delta_enable && !first) ? (i_in.in_byte - r_prev) : i_in.in_byte;
        len_nx   = r_run_len;
        val_nx   = r_run_val;
        rec      = '0;

        if (i_stored_mode) begin
            // flush an open run before the stored byte
            if (r_run_len != '0) begin
                rec.a_valid = 1'b1;
                rec.a_count = r_run_len;
                rec.a_value = r_run_val;
            end
            len_nx      = '0;
            rec.b_valid = 1'b1;
            rec.b_kind  = drle_pkg::KIND_STORED;
            rec.b_value = i_in.in_byte;
        end else if (r_run_len != '0 && coded == r_run_val
                     && r_run_len != drle_pkg::RUN_MAX) begin
            len_nx = r_run_len + 8'd1;
        end else begin
            if (r_run_len != '0) begin
                rec.a_valid = 1'b1;
                rec.a_count = r_run_len;
                rec.a_value = r_run_val;
            end
            val_nx = coded;
            len_nx = 8'd1;
        end

        if (i_in.in_last) begin
            if (len_nx != '0) begin
                rec.b_valid = 1'b1;
                rec.b_kind  = drle_pkg::KIND_RUN;
                rec.b_count = len_nx;
                rec.b_value = val_nx;
            end
            rec.t_valid = 1'b1;
            rec.t_crc   = crc_nx ^ drle_pkg::CRC_INIT;
            rec.t_total = total_nx;
        end
    end

    always_comb begin
        n_prev    = r_prev;
        n_run_val = r_run_val;
        n_run_len = r_run_len;
        n_crc     = r_crc;
        n_total   = r_total;
        if (accept) begin
            if (i_in.in_last) begin
                n_prev    = '0;
                n_run_val = '0;
                n_run_len = '0;
                n_crc     = drle_pkg::CRC_INIT;
                n_total   = '0;
            end else begin
                n_prev    = i_in.in_byte;
                n_run_val = val_nx;
                n_run_len = len_nx;
                n_crc     = crc_nx;
                n_total   = total_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_run_val <= '0;
            r_run_len <= '0;
            r_crc     <= drle_pkg::CRC_INIT;
            r_total   <= '0;
        end else begin
            r_prev    <= n_prev;
            r_run_val <= n_run_val;
            r_run_len <= n_run_len;
            r_crc     <= n_crc;
            r_total   <= n_total;
        end
    end

    assign o_rec_push = accept && (rec.a_valid || rec.b_valid || rec.t_valid);
    assign o_rec      = rec;

endmodule

@@ rtl/drle_fifo.sv @@
// ----------------------------------------------------------------------------
// drle_fifo
// Short record queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drle_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  drle_pkg::t_rec i_data,
    output logic           o_full,
    input  logic           i_pop,
    output drle_pkg::t_rec o_data,
    output logic           o_valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    drle_pkg::t_rec   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/drle_back.sv @@
// ----------------------------------------------------------------------------
// drle_back
// Unpack result records one beat at a time into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rec_valid,
    input  drle_pkg::t_rec      i_rec,
    output logic                o_rec_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output drle_pkg::t_out_item o_out
);

    logic [1:0]          r_done,      n_done;
    logic                r_out_valid, n_out_valid;
    drle_pkg::t_out_item r_out,       n_out;

    logic                load;
    logic                more;
    drle_pkg::t_out_item sel;

    assign load = i_rec_valid && (!r_out_valid || i_pop);

    // pick the oldest pending result of the head record
    always_comb begin
        sel  = '0;
        more = 1'b0;
        if (i_rec.a_valid && !r_done[0]) begin
            sel.out_kind  = drle_pkg::KIND_RUN;
            sel.out_count = i_rec.a_count;
            sel.out_value = i_rec.a_value;
            more          = i_rec.b_valid || i_rec.t_valid;
        end else if (i_rec.b_valid && !r_done[1]) begin
            sel.out_kind  = i_rec.b_kind;
            sel.out_count = i_rec.b_count;
            sel.out_value = i_rec.b_value;
            more          = i_rec.t_valid;
        end else begin
            sel.out_kind  = drle_pkg::KIND_TRAILER;
            sel.out_crc   = i_rec.t_crc;
            sel.out_total = i_rec.t_total;
            sel.out_last  = 1'b1;
        end
    end

    always_comb begin
        n_done      = r_done;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load) begin
            n_out_valid = 1'b1;
            n_out       = sel;
            if (more) begin
                n_done = (i_rec.a_valid && !r_done[0]) ? 2'b01 : 2'b11;
            end else begin
                n_done = 2'b00;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rec_pop = load && !more;
    assign o_empty   = !r_out_valid;
    assign o_out     = r_out;

endmodule

@@ rtl/delta_rle_encoder_crc32.sv @@
// ----------------------------------------------------------------------------
// delta_rle_encoder_crc32: results go through the record queue, then the output register.
// Throughput: one byte per cycle unless the queue is full; at most one result beat a cycle.
// Bytes causing 2 or 3 results take 2 or 3 output beats (record queue).
// Reset (synchronous, active low): config 0, CRC all ones, counts and queue empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delta_rle_encoder_crc32 #(
    parameter int unsigned REC_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input byte stream
    input  logic                push,
    input  drle_pkg::t_in_item  i_in,
    output logic                full,
    // result stream
    output logic                empty,
    input  logic                pop,
    output drle_pkg::t_out_item o_out,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic                i_cfg_data
);

    // Mode registers: the user must write them only while the block is idle; the block
    // does not enforce it. The front reads them directly. Unknown indexes are dropped.
    logic r_delta_enable, n_delta_enable;
    logic r_stored_mode,  n_stored_mode;

    // record channel between front and back
    logic           rec_push;
    logic           rec_full;
    drle_pkg::t_rec rec_in;
    logic           rec_pop;
    logic           rec_valid;
    drle_pkg::t_rec rec_head;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_delta_enable = r_delta_enable;
        n_stored_mode  = r_stored_mode;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                drle_pkg::CFG_DELTA_ENABLE: n_delta_enable = i_cfg_data;
                drle_pkg::CFG_STORED_MODE:  n_stored_mode  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_enable <= 1'b0;
            r_stored_mode  <= 1'b0;
        end else begin
            r_delta_enable <= n_delta_enable;
            r_stored_mode  <= n_stored_mode;
        end
    end

    // Front: one byte per beat. CRC step, saturating total, delta and run
    // compare all resolve in the accepting cycle; every byte that causes any
    // result pushes one record holding up to three of them.
    drle_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_in           (i_in),
        .o_full         (full),
        .i_delta_enable (r_delta_enable),
        .i_stored_mode  (r_stored_mode),
        .o_rec_push     (rec_push),
        .o_rec          (rec_in),
        .i_rec_full     (rec_full)
    );

    // Queue decouples the byte side from the result side.
    drle_fifo #(
        .DEPTH (REC_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (rec_in),
        .o_full  (rec_full),
        .i_pop   (rec_pop),
        .o_data  (rec_head),
        .o_valid (rec_valid)
    );

    // Back: advance through the head record, one result beat per cycle while the receiver
    // keeps popping, into an output register that refills in the same cycle it is popped.
    drle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec_head),
        .o_rec_pop   (rec_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

    // trailer and only the trailer marks the end of a block
    a_last_is_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out.out_last == (o_out.out_kind == drle_pkg::KIND_TRAILER)))
        else $error("out_last disagrees with result kind");

    // a run pair never carries an empty run
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.out_kind == drle_pkg::KIND_RUN) |-> (o_out.out_count != 8'd0))
        else $error("run pair with zero count");

    // the record queue never pops while it is empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_pop |-> rec_valid)
        else $error("record queue popped while empty");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte run-length encoder with CRC-32 trailer.
// A directed table covers the single-byte blocks, the three-beat step, delta
// wrap-around, dead register indexes and mode switches inside a block. Random
// blocks then run in four phases of sender idling and receiver stalling. One
// block pushes a run past 255. One receiver hold-off makes the block stall its
// input. Every result beat is checked against typed-in beats or the bench encoder model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int DRAIN_CYCLES   = 8;     // results pass the record queue, then the output register
    localparam int END_CYCLES     = 24;
    localparam int HOLD_CYCLES    = 100;   // receiver hold-off that fills the block
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES    = 8;
    localparam int LONG_RUN_BYTES = 257;   // one full run of 255, then more

    // register indexes the block must ignore
    localparam logic [7:0] CFG_FIRST_UNUSED = 8'd2;
    localparam logic [7:0] CFG_TOP_INDEX    = 8'hFF;

    typedef enum logic { ROW_CFG, ROW_BYTE } t_row_kind;

    // one line of the directed table: a register write or a byte; n_known > 0
    // means the result beats are typed in, otherwise the model supplies them
    typedef struct {
        t_row_kind           kind;
        logic [7:0]          idx;
        logic                val;
        logic [7:0]          b;
        logic                lst;
        int                  n_known;
        drle_pkg::t_out_item k0;
        drle_pkg::t_out_item k1;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    drle_pkg::t_in_item  i_in;
    logic                full;
    logic                empty;
    logic                pop = 1'b0;
    drle_pkg::t_out_item o_out;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [7:0]          i_cfg_index;
    logic                i_cfg_data;

    delta_rle_encoder_crc32 u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in       (i_in),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // encoder model state, a copy of what the block should hold
    logic                         m_delta;
    logic                         m_stored;
    logic [7:0]                   p_prev;
    logic [7:0]                   p_run_val;
    logic [7:0]                   p_run_len;
    logic [drle_pkg::CRC_W-1:0]   p_crc;
    logic [drle_pkg::TOTAL_W-1:0] p_total;

    drle_pkg::t_out_item step_beats[$];   // beats caused by the byte just accepted
    drle_pkg::t_out_item coded_beats[$];  // beats still owed by the block, oldest first
    t_dir_row            dir_rows[$];

    // random byte source
    logic [7:0] gen_prev;
    logic [7:0] gen_step;

    int send_idle_pct;
    int recv_stall_pct;
    bit want_hold;
    int hold_left;
    int idle_cycles;
    int n_fail;
    int n_bytes;
    int n_blocks;
    int n_checked;
    int n_cfg;
    int n_full_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------

    // reflected CRC-32, one bit per pass, low bit first
    function automatic logic [drle_pkg::CRC_W-1:0] crc32_step(
        input logic [drle_pkg::CRC_W-1:0] c, input logic [7:0] b);
        logic [drle_pkg::CRC_W-1:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ (drle_pkg::CRC_POLY & {drle_pkg::CRC_W{r[0] ^ b[i]}});
        end
        return r;
    endfunction

    function automatic drle_pkg::t_out_item run_res(input logic [7:0] cnt,
                                                    input logic [7:0] val);
        drle_pkg::t_out_item r;
        r = '0;
        r.out_kind  = drle_pkg::KIND_RUN;
        r.out_count = cnt;
        r.out_value = val;
        return r;
    endfunction

    function automatic drle_pkg::t_out_item stored_res(input logic [7:0] val);
        drle_pkg::t_out_item r;
        r = '0;
        r.out_kind  = drle_pkg::KIND_STORED;
        r.out_value = val;
        return r;
    endfunction

    function automatic drle_pkg::t_out_item trailer_res(
        input logic [drle_pkg::CRC_W-1:0] crc, input logic [drle_pkg::TOTAL_W-1:0] total);
        drle_pkg::t_out_item r;
        r = '0;
        r.out_kind  = drle_pkg::KIND_TRAILER;
        r.out_crc   = crc;
        r.out_total = total;
        r.out_last  = 1'b1;
        return r;
    endfunction

    function automatic void clear_block();
        p_prev    = 8'h00;
        p_run_val = 8'h00;
        p_run_len = 8'h00;
        p_crc     = drle_pkg::CRC_INIT;
        p_total   = '0;
    endfunction

    // Advance the model by one accepted byte and leave its beats in step_beats.
    function automatic void encode_byte(input logic [7:0] raw, input logic lst);
        logic       first;
        logic [7:0] coded;
        first = (p_total == '0);
        p_crc = crc32_step(p_crc, raw);
        if (p_total != drle_pkg::TOTAL_MAX) p_total = p_total + 1'b1;

        if (m_stored) begin
            // flush an open run before passing the byte through
            if (p_run_len != 8'h00) begin
                step_beats.push_back(run_res(p_run_len, p_run_val));
                p_run_len = 8'h00;
            end
            step_beats.push_back(stored_res(raw));
        end else begin
            // the first byte of a block is never delta-coded
            coded = (m_delta && !first) ? raw - p_prev : raw;
            if (p_run_len != 8'h00 && coded == p_run_val
                && p_run_len != drle_pkg::RUN_MAX) begin
                p_run_len = p_run_len + 1'b1;
            end else begin
                // a full run closes even when the byte matches
                if (p_run_len != 8'h00) step_beats.push_back(run_res(p_run_len, p_run_val));
                p_run_val = coded;
                p_run_len = 8'd1;
            end
        end
        p_prev = raw;

        if (lst) begin
            if (p_run_len != 8'h00) step_beats.push_back(run_res(p_run_len, p_run_val));
            step_beats.push_back(trailer_res(p_crc ^ drle_pkg::CRC_INIT, p_total));
            clear_block();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------

    function automatic t_dir_row cfg_row(input logic [7:0] idx, input logic val);
        t_dir_row r;
        r = '{ROW_CFG, idx, val, 8'h00, 1'b0, 0, '0, '0};
        return r;
    endfunction

    function automatic t_dir_row byte_row(input logic [7:0] b, input logic lst);
        t_dir_row r;
        r = '{ROW_BYTE, 8'h00, 1'b0, b, lst, 0, '0, '0};
        return r;
    endfunction

    function automatic t_dir_row known_row(input logic [7:0] b, input logic lst,
                                           input drle_pkg::t_out_item k0,
                                           input drle_pkg::t_out_item k1);
        t_dir_row r;
        r = '{ROW_BYTE, 8'h00, 1'b0, b, lst, 2, k0, k1};
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one byte, hold it until the block takes it, then record the beats
    // it owes: typed-in ones when given, else the model's.
    task automatic send_byte(input logic [7:0] b, input logic lst, input int n_known,
                             input drle_pkg::t_out_item k0, input drle_pkg::t_out_item k1);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= '{in_byte: b, in_last: lst};
        @(posedge i_clk);
        while (full) @(posedge i_clk);

        encode_byte(b, lst);
        if (n_known == 0) begin
            while (step_beats.size() != 0) coded_beats.push_back(step_beats.pop_front());
        end else begin
            step_beats.delete();
            coded_beats.push_back(k0);
            if (n_known > 1) coded_beats.push_back(k1);
        end
        n_bytes++;
        if (lst) n_blocks++;
    endtask

    // Stop offering, let every owed beat come out, then let the block settle
    // a step that produced nothing.
    task automatic drain_outputs();
        push        <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (coded_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leave valid high on return; the next action lowers or reuses it.
    task automatic cfg_write(input logic [7:0] idx, input logic val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == drle_pkg::CFG_DELTA_ENABLE) m_delta = val;
        else if (idx == drle_pkg::CFG_STORED_MODE) m_stored = val;
        n_cfg++;
    endtask

    // Mostly a live register, now and then an index the block must drop.
    task automatic random_cfg_write();
        logic [7:0] idx;
        drain_outputs();
        if ($urandom_range(0, 9) == 0) begin
            idx = 8'($urandom_range(CFG_FIRST_UNUSED, CFG_TOP_INDEX));
        end else begin
            idx = 8'($urandom_range(drle_pkg::CFG_DELTA_ENABLE, drle_pkg::CFG_STORED_MODE));
        end
        cfg_write(idx, 1'($urandom_range(0, 1)));
    endtask

    // Repeat the last step often so runs and delta runs form, with the byte
    // extremes mixed in.
    function automatic logic [7:0] pick_byte();
        int         r;
        logic [7:0] raw;
        r = $urandom_range(0, 99);
        if (r < 45) raw = gen_prev + (m_delta ? gen_step : 8'h00);
        else if (r < 55) raw = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else raw = 8'($urandom_range(0, 255));
        gen_step = raw - gen_prev;
        gen_prev = raw;
        return raw;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side and checking
    // ------------------------------------------------------------------------

    task automatic check_result(input drle_pkg::t_out_item got);
        drle_pkg::t_out_item want;
        if (coded_beats.size() == 0) begin
            $error("result beat with nothing owed: kind %0d value %0h",
                   got.out_kind, got.out_value);
            n_fail++;
            return;
        end
        want = coded_beats.pop_front();
        if (got.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
            n_fail++;
        end
        if (got.out_count !== want.out_count) begin
            $error("out_count: expected %0d, got %0d", want.out_count, got.out_count);
            n_fail++;
        end
        if (got.out_value !== want.out_value) begin
            $error("out_value: expected %0h, got %0h", want.out_value, got.out_value);
            n_fail++;
        end
        if (got.out_crc !== want.out_crc) begin
            $error("out_crc: expected %08h, got %08h", want.out_crc, got.out_crc);
            n_fail++;
        end
        if (got.out_total !== want.out_total) begin
            $error("out_total: expected %0d, got %0d", want.out_total, got.out_total);
            n_fail++;
        end
        if (got.out_last !== want.out_last) begin
            $error("out_last: expected %0d, got %0d", want.out_last, got.out_last);
            n_fail++;
        end
    endtask

    // Take a beat whenever pop and !empty meet at the edge, then pick the
    // next pop: held low through a requested hold-off, else random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_result(o_out);
                n_checked++;
            end
            if (want_hold) begin
                hold_left = HOLD_CYCLES;
                want_hold = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && full) n_full_cycles++;
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb_top: no beat for %0d cycles, %0d results still owed",
                             idle_cycles, coded_beats.size());
                    $display("tb_top: errors");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin
        int         snd_pct [4];
        int         rcv_pct [4];
        logic       ph_delta [4];
        logic       ph_stored[4];
        int         ph_bytes;
        int         blk;
        int         len;
        logic [7:0] b;

        snd_pct   = '{0, 82, 0, 19};
        rcv_pct   = '{0, 0, 82, 19};
        ph_delta  = '{1'b0, 1'b1, 1'b0, 1'b1};
        ph_stored = '{1'b1, 1'b0, 1'b0, 1'b1};

        // every input known from time zero, with reset held low first
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_in           = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = 1'b0;
        m_delta        = 1'b0;
        m_stored       = 1'b0;
        gen_prev       = 8'h00;
        gen_step       = 8'h00;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        want_hold      = 1'b0;
        hold_left      = 0;
        idle_cycles    = 0;
        n_fail         = 0;
        n_bytes        = 0;
        n_blocks       = 0;
        n_checked      = 0;
        n_cfg          = 0;
        n_full_cycles  = 0;
        clear_block();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Reset config is plain run-length coding.
        // Single-byte blocks at both byte extremes: one run pair and a trailer.
        dir_rows.push_back(known_row(8'h00, 1'b1, run_res(8'd1, 8'h00),
                                     trailer_res(32'hD202_EF8D, 48'd1)));
        dir_rows.push_back(known_row(8'hFF, 1'b1, run_res(8'd1, 8'hFF),
                                     trailer_res(32'hFF00_0000, 48'd1)));
        // writes to dead indexes must change nothing
        dir_rows.push_back(cfg_row(CFG_FIRST_UNUSED, 1'b1));
        dir_rows.push_back(cfg_row(CFG_TOP_INDEX, 1'b1));
        // runs of three then two, closed by the last byte
        dir_rows.push_back(byte_row(8'h41, 1'b0));
        dir_rows.push_back(byte_row(8'h41, 1'b0));
        dir_rows.push_back(byte_row(8'h41, 1'b0));
        dir_rows.push_back(byte_row(8'h42, 1'b0));
        dir_rows.push_back(byte_row(8'h42, 1'b1));
        // last byte breaks a run: closed pair, final pair and trailer in one step
        dir_rows.push_back(byte_row(8'h10, 1'b0));
        dir_rows.push_back(byte_row(8'h10, 1'b0));
        dir_rows.push_back(byte_row(8'h20, 1'b1));
        // delta coding: first byte raw, then a run of steps, then a wrapping step
        dir_rows.push_back(cfg_row(drle_pkg::CFG_DELTA_ENABLE, 1'b1));
        dir_rows.push_back(byte_row(8'h05, 1'b0));
        dir_rows.push_back(byte_row(8'h07, 1'b0));
        dir_rows.push_back(byte_row(8'h09, 1'b0));
        dir_rows.push_back(byte_row(8'h0B, 1'b1));
        dir_rows.push_back(byte_row(8'h02, 1'b0));
        dir_rows.push_back(byte_row(8'h01, 1'b0));
        dir_rows.push_back(byte_row(8'h00, 1'b1));
        // stored mode ignores delta_enable
        dir_rows.push_back(cfg_row(drle_pkg::CFG_STORED_MODE, 1'b1));
        dir_rows.push_back(known_row(8'h00, 1'b1, stored_res(8'h00),
                                     trailer_res(32'hD202_EF8D, 48'd1)));
        dir_rows.push_back(known_row(8'hFF, 1'b1, stored_res(8'hFF),
                                     trailer_res(32'hFF00_0000, 48'd1)));
        dir_rows.push_back(byte_row(8'hAB, 1'b1));
        // switch to stored mode with a run open, then back to delta mid-block
        dir_rows.push_back(cfg_row(drle_pkg::CFG_STORED_MODE, 1'b0));
        dir_rows.push_back(cfg_row(drle_pkg::CFG_DELTA_ENABLE, 1'b0));
        dir_rows.push_back(byte_row(8'h33, 1'b0));
        dir_rows.push_back(byte_row(8'h33, 1'b0));
        dir_rows.push_back(cfg_row(drle_pkg::CFG_STORED_MODE, 1'b1));
        dir_rows.push_back(byte_row(8'h34, 1'b0));
        dir_rows.push_back(cfg_row(drle_pkg::CFG_STORED_MODE, 1'b0));
        dir_rows.push_back(cfg_row(drle_pkg::CFG_DELTA_ENABLE, 1'b1));
        dir_rows.push_back(byte_row(8'h36, 1'b0));
        dir_rows.push_back(byte_row(8'h38, 1'b1));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_outputs();
                cfg_write(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].n_known,
                          dir_rows[i].k0, dir_rows[i].k1);
            end
        end

        // Random blocks in four phases: no idling, sender idle, receiver
        // stalling, both. Each phase starts from a fixed setting, then drifts.
        for (int ph = 0; ph < 4; ph++) begin
            drain_outputs();
            send_idle_pct  = snd_pct[ph];
            recv_stall_pct = rcv_pct[ph];
            cfg_write(drle_pkg::CFG_DELTA_ENABLE, ph_delta[ph]);
            cfg_write(drle_pkg::CFG_STORED_MODE, ph_stored[ph]);
            ph_bytes = 0;
            blk      = 0;
            while (ph_bytes < PHASE_BYTES) begin
                if (blk != 0 && $urandom_range(0, 4) == 0) random_cfg_write();
                if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 12);
                else len = $urandom_range(13, 40);

                if (ph == 0 && blk == 0) begin
                    // stored mode, no sender gaps: hold the receiver off and
                    // keep offering until the block pushes back
                    want_hold = 1'b1;
                    len       = 48;
                end

                if (ph == 1 && blk == 0) begin
                    // delta on: one raw byte, then zeros past the run limit
                    for (int k = 0; k < LONG_RUN_BYTES; k++) begin
                        send_byte(8'h5A, k == LONG_RUN_BYTES - 1, 0, '0, '0);
                    end
                end else begin
                    for (int k = 0; k < len; k++) begin
                        if (k != 0 && $urandom_range(0, 49) == 0) random_cfg_write();
                        b = pick_byte();
                        send_byte(b, k == len - 1, 0, '0, '0);
                        ph_bytes++;
                    end
                end

                // pause the sender once until everything owed has come out
                if (ph == 2 && blk == 0) drain_outputs();
                blk++;
            end
        end

        // wind down: stop offering, stop stalling, collect the rest
        push           <= 1'b0;
        i_cfg_valid    <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (coded_beats.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d bytes in %0d blocks, %0d beats checked, %0d register writes",
                 n_bytes, n_blocks, n_checked, n_cfg);
        $display("tb_top: all modes, mid-block switches, run past 255, input held %0d cycles",
                 n_full_cycles);
        if (n_fail == 0 && coded_beats.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/drle_pkg.sv
rtl/drle_front.sv
rtl/drle_fifo.sv
rtl/drle_back.sv
rtl/delta_rle_encoder_crc32.sv
bench/tb_top.sv
